// ----- hdl/musis_pkg.sv -----
// shared constants and types for the masked uniform index sampler
// used by musis_core and masked_uniform_index_sampler; depends on nothing

package musis_pkg;

   // field widths
   localparam int RAND_W = 16;
   localparam int OUT_W  = 10;
   localparam int MASK_W = 13;

   // range mask limits
   localparam logic [MASK_W-1:0] MASK_MIN = 13'h0001;
   localparam logic [MASK_W-1:0] MASK_MAX = 13'h1FFF;

   // parameter defaults
   localparam int DEF_ITEM_COUNT      = 1024;
   localparam int DEF_WORDS_PER_INDEX = 8;

   // one result item
   typedef struct packed {
      logic [OUT_W-1:0] position;
      logic [OUT_W-1:0] index_value;
      logic             last_of_run;
   } rsp_type;

endpackage

// ----- hdl/musis_core.sv -----
// sampler state and per-word datapath: mask, bound compare, offset keep, position walk
// depends on musis_pkg

module musis_core #(
   parameter int ITEM_COUNT      = musis_pkg::DEF_ITEM_COUNT,
   parameter int WORDS_PER_INDEX = musis_pkg::DEF_WORDS_PER_INDEX
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [musis_pkg::RAND_W-1:0] word,
   output logic                        emit,
   output musis_pkg::rsp_type          result
);

   localparam int PW = (ITEM_COUNT > 2) ? $clog2(ITEM_COUNT) : 1;
   localparam int CW = (WORDS_PER_INDEX > 1) ? $clog2(WORDS_PER_INDEX) : 1;
   localparam int MW = musis_pkg::MASK_W;
   localparam logic [PW-1:0] TOP      = PW'(ITEM_COUNT - 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(WORDS_PER_INDEX - 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [MW-1:0] mask_ff, mask_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] off_ff, off_in;

   logic [MW-1:0] bound, bound_next, cand, off_cur, pos_ext, sum;
   logic          last;

   // bound compare on the masked word
   always_comb begin
      bound      = MW'(TOP - pos_ff);
      bound_next = bound + MW'(1);
      cand       = word[MW-1:0] & mask_ff;
      off_cur    = (cand <= bound) ? cand : off_ff;
      last       = (cnt_ff == LAST_CNT);
      pos_ext    = MW'(pos_ff);
      sum        = pos_ext + off_cur;
   end

   // result for the final word of each index's group of words
   assign emit               = step & last;
   assign result.position    = musis_pkg::OUT_W'(pos_ff);
   assign result.index_value = sum[musis_pkg::OUT_W-1:0];
   assign result.last_of_run = (pos_ff == '0);

   // next state
   always_comb begin
      pos_in  = pos_ff;
      mask_in = mask_ff;
      cnt_in  = cnt_ff;
      off_in  = off_ff;
      if (step) begin
         if (last) begin
            cnt_in = '0;
            off_in = '0;
            if (pos_ff == '0) begin
               pos_in  = TOP;
               mask_in = musis_pkg::MASK_MIN;
            end else begin
               pos_in = pos_ff - PW'(1);
               // grow the mask by one bit once the bound passes it
               if (bound_next > mask_ff && mask_ff < musis_pkg::MASK_MAX) begin
                  mask_in = {mask_ff[MW-2:0], 1'b1};
               end
            end
         end else begin
            cnt_in = cnt_ff + CW'(1);
            off_in = off_cur;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= TOP;
         mask_ff <= musis_pkg::MASK_MIN;
         cnt_ff  <= '0;
         off_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         mask_ff <= mask_in;
         cnt_ff  <= cnt_in;
         off_ff  <= off_in;
      end
   end

endmodule

// ----- hdl/masked_uniform_index_sampler.sv -----
// flow: a word taken from req_ waits in the input register until the result register is free,
// then its result (if any) is registered in the result register and presented on rsp_
// throughput: one random word per cycle while rsp_stall is low, one result per WORDS_PER_INDEX words,
// set by the input register and result register handing over in the same cycle
// reset: synchronous; restarts at position ITEM_COUNT-1 with the mask at one, both
// stages empty
// top level: input register, musis_core datapath, result register; depends on musis_pkg

module masked_uniform_index_sampler #(
   parameter int ITEM_COUNT      = musis_pkg::DEF_ITEM_COUNT,
   parameter int WORDS_PER_INDEX = musis_pkg::DEF_WORDS_PER_INDEX
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [musis_pkg::RAND_W-1:0] req_rand_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [musis_pkg::OUT_W-1:0]  rsp_position,
   output logic [musis_pkg::OUT_W-1:0]  rsp_index_value,
   output logic                         rsp_last_of_run
);

   logic                         in_valid_ff, in_valid_in;
   logic [musis_pkg::RAND_W-1:0] word_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   musis_pkg::rsp_type           rsp_ff;
   musis_pkg::rsp_type           core_result;
   logic                         out_free, step, emit, req_take;

   // handshake control
   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign step         = in_valid_ff & out_free;
   assign req_stall    = in_valid_ff & ~out_free;
   assign req_take     = req_valid & ~req_stall;
   assign in_valid_in  = req_take | (in_valid_ff & ~step);
   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   musis_core #(
      .ITEM_COUNT      (ITEM_COUNT),
      .WORDS_PER_INDEX (WORDS_PER_INDEX)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (word_ff),
      .emit   (emit),
      .result (core_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         word_ff <= req_rand_word;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_ff.position;
   assign rsp_index_value = rsp_ff.index_value;
   assign rsp_last_of_run = rsp_ff.last_of_run;

endmodule

// ----- test/tb_masked_uniform_index_sampler.sv -----
// testbench for masked_uniform_index_sampler: random words in, swap indexes checked per field
// depends on musis_pkg and the sampler rtl; built-in predictor of the shuffle index stream

module tb_masked_uniform_index_sampler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT      = musis_pkg::DEF_ITEM_COUNT;
   localparam int WORDS_PER_INDEX = musis_pkg::DEF_WORDS_PER_INDEX;
   localparam int RESET_CYCLES    = 12;
   // random words after the directed ones, about 900 transfers in all
   localparam int RANDOM_WORDS    = 876;
   localparam int CALM_TAIL       = 200;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TIMEOUT_NS      = 5_000_000;

   // first position: bound 0, mask 1, only even words fit
   // second position: bound 1, mask 1, every word fits, last one odd so index hits the top
   // third position: bound 2, mask 3, every word ends in 11 so none fits
   localparam logic [musis_pkg::RAND_W-1:0] DIRECTED_WORDS [24] = '{
      16'hFFFF, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'hFFFF,
      16'h0000, 16'hFFFF, 16'h0000, 16'h7FFE, 16'h8001, 16'hAAAA, 16'h5554, 16'h0001,
      16'hFFFF, 16'h0003, 16'h7FFF, 16'h8003, 16'h5557, 16'hAAAB, 16'h000F, 16'hFFFF
   };

   // predictor of the index stream plus queue of indexes still to come
   class index_scoreboard;
      int unsigned                  cur_position;
      logic [musis_pkg::MASK_W-1:0] range_mask;
      int unsigned                  words_taken;
      int unsigned                  kept_offset;
      musis_pkg::rsp_type           expected_indexes[$];
      int unsigned                  mismatches;

      function new();
         cur_position = ITEM_COUNT - 1;
         range_mask   = musis_pkg::MASK_MIN;
         words_taken  = 0;
         kept_offset  = 0;
         mismatches   = 0;
      endfunction

      function int unsigned bound();
         return ITEM_COUNT - 1 - cur_position;
      endfunction

      // one accepted random word
      function void take_word(input logic [musis_pkg::RAND_W-1:0] word);
         int unsigned        cand;
         musis_pkg::rsp_type idx;
         cand = word & musis_pkg::RAND_W'(range_mask);
         if (cand <= bound()) kept_offset = cand;
         words_taken++;
         if (words_taken == WORDS_PER_INDEX) begin
            idx.position    = musis_pkg::OUT_W'(cur_position);
            idx.index_value = musis_pkg::OUT_W'(cur_position + kept_offset);
            idx.last_of_run = (cur_position == 0);
            expected_indexes.push_back(idx);
            words_taken = 0;
            kept_offset = 0;
            // wrap to the top after position zero, else step down and widen the mask
            if (cur_position == 0) begin
               cur_position = ITEM_COUNT - 1;
               range_mask   = musis_pkg::MASK_MIN;
            end else begin
               cur_position--;
               if (bound() > range_mask && range_mask < musis_pkg::MASK_MAX)
                  range_mask = (range_mask << 1) | 1'b1;
            end
         end
      endfunction

      // one accepted result against the oldest expected index
      function void check_index(input musis_pkg::rsp_type got);
         musis_pkg::rsp_type want;
         if (expected_indexes.size() == 0) begin
            $display("%0t: unexpected result: position %0d index %0d last %0d",
                     $time, got.position, got.index_value, got.last_of_run);
            mismatches++;
            return;
         end
         want = expected_indexes.pop_front();
         if (got.position !== want.position) begin
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, want.position, got.position);
            mismatches++;
         end
         if (got.index_value !== want.index_value) begin
            $display("%0t: index_value mismatch: expected %0d, actual %0d",
                     $time, want.index_value, got.index_value);
            mismatches++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch: expected %0d, actual %0d",
                     $time, want.last_of_run, got.last_of_run);
            mismatches++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [musis_pkg::RAND_W-1:0] req_rand_word = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [musis_pkg::OUT_W-1:0]  rsp_position;
   logic [musis_pkg::OUT_W-1:0]  rsp_index_value;
   logic                         rsp_last_of_run;

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;

   index_scoreboard idx_sb = new();

   masked_uniform_index_sampler #(
      .ITEM_COUNT      (ITEM_COUNT),
      .WORDS_PER_INDEX (WORDS_PER_INDEX)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rand_word   (req_rand_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_index_value (rsp_index_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard limit on the whole run
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   // receiver backpressure in bursts of random length
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result transfers go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         idx_sb.check_index('{rsp_position, rsp_index_value, rsp_last_of_run});
   end

   // one word transfer, optionally after an idle gap
   task automatic send_word(input logic [musis_pkg::RAND_W-1:0] word, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rand_word <= word;
      do @(posedge clock); while (req_stall);
      idx_sb.take_word(word);
   endtask

   // hold off the sender until every expected index has come back or DRAIN_LIMIT is reached
   task automatic drain_results();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (idx_sb.expected_indexes.size() != 0 && guard < DRAIN_LIMIT);
   endtask

   initial begin
      logic [musis_pkg::RAND_W-1:0] word;
      int unsigned                  low;
      int unsigned                  gap;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: word extremes, no fitting word, top index value
      for (int i = 0; i < 24; i++) send_word(DIRECTED_WORDS[i], 0);
      drain_results();

      // random words, low bits often placed on or just past the current bound
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               gap_pct   = 0;
               stall_pct = 0;
            end else begin
               gap_pct   = $urandom_range(5, 40);
               stall_pct = $urandom_range(5, 40);
            end
         end
         if (n >= RANDOM_WORDS - CALM_TAIL) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         if (n == RANDOM_WORDS / 2) drain_results();
         case ($urandom_range(0, 3))
            0:       low = idx_sb.bound();
            1:       low = idx_sb.bound() + 1;
            default: low = $urandom_range(0, 65535);
         endcase
         word = $urandom_range(0, 65535);
         word = (word & ~musis_pkg::RAND_W'(idx_sb.range_mask))
              | (musis_pkg::RAND_W'(low) & musis_pkg::RAND_W'(idx_sb.range_mask));
         gap = 0;
         if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 8);
         send_word(word, gap);
      end

      // wait out the last results
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (idx_sb.expected_indexes.size() != 0) begin
         $display("%0t: %0d expected results never arrived, first position %0d",
                  $time, idx_sb.expected_indexes.size(),
                  idx_sb.expected_indexes[0].position);
         idx_sb.mismatches++;
      end

      if (idx_sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- masked_uniform_index_sampler.f -----
hdl/musis_pkg.sv
hdl/musis_core.sv
hdl/masked_uniform_index_sampler.sv
test/tb_masked_uniform_index_sampler.sv
